@@ hdl/pnz_pkg.sv @@
// -----------------------------------------------------------------------------
// pnz_pkg
// Shared constants, types and helpers for the 3D gradient noise pipeline.
// -----------------------------------------------------------------------------
package pnz_pkg;

    localparam int COORD_W        = 32;
    localparam int NOISE_W        = 16;
    localparam int DEF_COORD_FRAC = 16;
    localparam int DEF_OUT_FRAC   = 14;

    // Permutation table, 256 entries of 8 bits.
    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        perm_lookup = PERM[idx];
    endfunction

    // Hash and fraction data handed from front to back.
    typedef struct packed {
        logic [7:0]  h_aa;
        logic [7:0]  h_ba;
        logic [7:0]  h_ab;
        logic [7:0]  h_bb;
        logic [7:0]  h_aa1;
        logic [7:0]  h_ba1;
        logic [7:0]  h_ab1;
        logic [7:0]  h_bb1;
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] fz;
    } t_cell;

endpackage

@@ hdl/pnz_if.sv @@
// -----------------------------------------------------------------------------
// pnz_coord_if / pnz_noise_if
// Valid/ready channels for the coordinate and noise words.
// -----------------------------------------------------------------------------
interface pnz_coord_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pnz_noise_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

@@ hdl/pnz_front.sv @@
// -----------------------------------------------------------------------------
// pnz_front
// Splits coordinates into cell and fraction and walks the permutation hash
// over three registered stages. Stalls as one unit on i_ready.
// -----------------------------------------------------------------------------
module pnz_front #(
    parameter int COORD_FRAC = pnz_pkg::DEF_COORD_FRAC
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_pos_x,
    input  logic [31:0]    i_pos_y,
    input  logic [31:0]    i_pos_z,
    output logic           o_valid,
    input  logic           i_ready,
    output pnz_pkg::t_cell o_cell
);
    import pnz_pkg::*;

    localparam int F = COORD_FRAC;

    logic        adv;
    logic [2:0]  r_vld;
    logic [7:0]  r1_cz, r1_a, r1_b;
    logic [7:0]  r2_aa, r2_ab, r2_ba, r2_bb;
    logic [23:0] r1_fx, r1_fy, r1_fz, r2_fx, r2_fy, r2_fz;
    t_cell       r3_cell;
    logic [7:0]  cx, cy, cz, aa, ab, ba, bb;

    assign adv     = !r_vld[2] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[2];
    assign o_cell  = r3_cell;

    assign cx = i_pos_x[F +: 8];
    assign cy = i_pos_y[F +: 8];
    assign cz = i_pos_z[F +: 8];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // stage 1: first level hash
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a  <= perm_lookup(cx) + cy;
            r1_b  <= perm_lookup(cx + 8'd1) + cy;
            r1_cz <= cz;
            r1_fx <= 24'(i_pos_x[F-1:0]);
            r1_fy <= 24'(i_pos_y[F-1:0]);
            r1_fz <= 24'(i_pos_z[F-1:0]);
        end
    end

    assign aa = perm_lookup(r1_a) + r1_cz;
    assign ab = perm_lookup(r1_a + 8'd1) + r1_cz;
    assign ba = perm_lookup(r1_b) + r1_cz;
    assign bb = perm_lookup(r1_b + 8'd1) + r1_cz;

    // stage 2: second level hash
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_aa <= aa;
            r2_ab <= ab;
            r2_ba <= ba;
            r2_bb <= bb;
            r2_fx <= r1_fx;
            r2_fy <= r1_fy;
            r2_fz <= r1_fz;
        end
    end

    // stage 3: corner hashes
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_cell.h_aa  <= perm_lookup(r2_aa);
            r3_cell.h_ba  <= perm_lookup(r2_ba);
            r3_cell.h_ab  <= perm_lookup(r2_ab);
            r3_cell.h_bb  <= perm_lookup(r2_bb);
            r3_cell.h_aa1 <= perm_lookup(r2_aa + 8'd1);
            r3_cell.h_ba1 <= perm_lookup(r2_ba + 8'd1);
            r3_cell.h_ab1 <= perm_lookup(r2_ab + 8'd1);
            r3_cell.h_bb1 <= perm_lookup(r2_bb + 8'd1);
            r3_cell.fx    <= r2_fx;
            r3_cell.fy    <= r2_fy;
            r3_cell.fz    <= r2_fz;
        end
    end

endmodule

@@ hdl/pnz_fifo.sv @@
// -----------------------------------------------------------------------------
// pnz_fifo
// Small register queue between hash front end and arithmetic back end.
// -----------------------------------------------------------------------------
module pnz_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pnz_pkg::t_cell i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output pnz_pkg::t_cell o_data
);
    import pnz_pkg::*;

    localparam int DEPTH = 4;

    t_cell      r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 3'(DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

@@ hdl/pnz_back.sv @@
// -----------------------------------------------------------------------------
// pnz_back
// Fade curves, corner gradients, trilinear blend and output scaling.
// Eleven-stage pipeline stalled as one unit; last stage is the output reg.
// -----------------------------------------------------------------------------
module pnz_back #(
    parameter int COORD_FRAC = pnz_pkg::DEF_COORD_FRAC,
    parameter int OUT_FRAC   = pnz_pkg::DEF_OUT_FRAC
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pnz_pkg::t_cell i_cell,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_noise
);
    import pnz_pkg::*;

    localparam int F   = COORD_FRAC;
    localparam int NS  = 11;
    localparam int W   = 32;
    localparam logic signed [W-1:0] ONE  = W'(1) << F;
    localparam logic signed [W-1:0] HALF = W'(1) << (F - 1);

    // round-half-up product scaled back by F
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [2*W-1:0] p;
        p = x * y + (2*W)'(HALF);
        qmul = W'(p >>> F);
    endfunction

    function automatic logic signed [W-1:0] grad(input logic [7:0] hs,
        input logic signed [W-1:0] x, input logic signed [W-1:0] y,
        input logic signed [W-1:0] z);
        logic [3:0] h;
        logic signed [W-1:0] u, v;
        h = hs[3:0];
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        grad = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [W-1:0] clamp01(input logic signed [W-1:0] x);
        if (x < 0) clamp01 = '0;
        else if (x > ONE) clamp01 = ONE;
        else clamp01 = x;
    endfunction

    logic          adv;
    logic [NS-1:0] r_vld;

    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // fade lanes: t, then 4 multiply steps; fraction carried alongside
    logic signed [W-1:0] r_t  [5][3];
    logic signed [W-1:0] r_fd [1:4][3];
    t_cell               r_c  [5];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c[0] <= i_cell;
            r_t[0][0] <= W'(i_cell.fx);
            r_t[0][1] <= W'(i_cell.fy);
            r_t[0][2] <= W'(i_cell.fz);
            for (int k = 0; k < 3; k++) begin
                r_fd[1][k] <= qmul(r_t[0][k], 6 * r_t[0][k] - 15 * ONE) + 10 * ONE;
                r_fd[2][k] <= qmul(r_fd[1][k], r_t[1][k]);
                r_fd[3][k] <= qmul(r_fd[2][k], r_t[2][k]);
                r_fd[4][k] <= clamp01(qmul(r_fd[3][k], r_t[3][k]));
            end
            for (int s = 1; s < 5; s++) begin
                r_c[s] <= r_c[s-1];
                r_t[s] <= r_t[s-1];
            end
        end
    end

    // stage 6: corner gradients
    logic signed [W-1:0] r_g [8];
    logic signed [W-1:0] r_w6 [3];
    logic signed [W-1:0] x0, y0, z0, x1, y1, z1;

    assign x0 = r_t[4][0];
    assign y0 = r_t[4][1];
    assign z0 = r_t[4][2];
    assign x1 = x0 - ONE;
    assign y1 = y0 - ONE;
    assign z1 = z0 - ONE;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g[0] <= grad(r_c[4].h_aa,  x0, y0, z0);
            r_g[1] <= grad(r_c[4].h_ba,  x1, y0, z0);
            r_g[2] <= grad(r_c[4].h_ab,  x0, y1, z0);
            r_g[3] <= grad(r_c[4].h_bb,  x1, y1, z0);
            r_g[4] <= grad(r_c[4].h_aa1, x0, y0, z1);
            r_g[5] <= grad(r_c[4].h_ba1, x1, y0, z1);
            r_g[6] <= grad(r_c[4].h_ab1, x0, y1, z1);
            r_g[7] <= grad(r_c[4].h_bb1, x1, y1, z1);
            for (int k = 0; k < 3; k++) r_w6[k] <= r_fd[4][k];
        end
    end

    // stages 7-9: lerp along x, y, z
    logic signed [W-1:0] r_lx [4];
    logic signed [W-1:0] r_ly [2];
    logic signed [W-1:0] r_lz;
    logic signed [W-1:0] r_w7 [2];
    logic signed [W-1:0] r_w8;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++)
                r_lx[k] <= r_g[2*k] + qmul(r_w6[0], r_g[2*k+1] - r_g[2*k]);
            r_w7[0] <= r_w6[1];
            r_w7[1] <= r_w6[2];
            for (int k = 0; k < 2; k++)
                r_ly[k] <= r_lx[2*k] + qmul(r_w7[0], r_lx[2*k+1] - r_lx[2*k]);
            r_w8 <= r_w7[1];
            r_lz <= r_ly[0] + qmul(r_w8, r_ly[1] - r_ly[0]);
        end
    end

    // stage 10-11: scale to output format, then saturate
    logic signed [W+8:0] scaled;
    logic signed [W+8:0] r_sc;
    logic [15:0]         r_out;

    always_comb begin
        if (OUT_FRAC >= F)
            scaled = (W+9)'(r_lz) <<< (OUT_FRAC - F);
        else
            scaled = ((W+9)'(r_lz) + ((W+9)'(1) <<< (F - OUT_FRAC - 1))) >>> (F - OUT_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc <= scaled;
            if (r_sc > 32767)
                r_out <= 16'h7fff;
            else if (r_sc < -32768)
                r_out <= 16'h8000;
            else
                r_out <= r_sc[15:0];
        end
    end

    assign o_noise = r_out;

endmodule

@@ hdl/perlin_noise_3d.sv @@
// -----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise: Q16.16 point in, saturated Q2.14 noise out.
//
//   channel    dir   words               handshake
//   s_coord    in    pos_x, pos_y, pos_z valid/ready
//   m_noise    out   noise_value         valid/ready
//
// One word per cycle sustained while m_noise is ready; 3 hash stages,
// 1 queue stage and 11 arithmetic stages. The fade chain of four multiplies
// sets the depth. Synchronous active-low reset clears all valids and the
// queue. A stall on m_noise halts the back end; the 4-entry queue lets the
// hash front end keep running until it fills.
// -----------------------------------------------------------------------------
module perlin_noise_3d #(
    parameter int COORD_FRAC_BITS = pnz_pkg::DEF_COORD_FRAC,
    parameter int OUT_FRAC_BITS   = pnz_pkg::DEF_OUT_FRAC
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnz_coord_if.sink   s_coord,
    pnz_noise_if.source m_noise
);
    import pnz_pkg::*;

    logic  f_valid, f_ready, q_valid, q_ready;
    t_cell f_cell, q_cell;

    pnz_front #(.COORD_FRAC(COORD_FRAC_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_coord.valid), .o_ready(s_coord.ready),
        .i_pos_x(s_coord.pos_x), .i_pos_y(s_coord.pos_y), .i_pos_z(s_coord.pos_z),
        .o_valid(f_valid), .i_ready(f_ready), .o_cell(f_cell)
    );

    pnz_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cell),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cell)
    );

    pnz_back #(.COORD_FRAC(COORD_FRAC_BITS), .OUT_FRAC(OUT_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_cell(q_cell),
        .o_valid(m_noise.valid), .i_ready(m_noise.ready), .o_noise(m_noise.noise_value)
    );

    // a held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_noise.valid && !m_noise.ready |=> $stable(m_noise.noise_value))
        else $error("noise word changed under stall");

    // the queue never offers a word while empty after reset
    a_q_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !q_valid)
        else $error("queue valid after reset");

    // front end only stalls when the queue is full
    a_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |-> q_valid)
        else $error("queue full but empty");

endmodule
